@@ hw/rtl/cartridge_bank_switch_mapper_defines.svh @@
// ----------------------------------------------------------------------------
// Cartridge mapper assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_SWITCH_MAPPER_DEFINES_SVH
`define CARTRIDGE_BANK_SWITCH_MAPPER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define CBSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CBSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/cbsm_pkg.sv @@
// ----------------------------------------------------------------------------
// Cartridge mapper package
// Mapping modes, register indexes, hotspot and window addresses, shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbsm_pkg;

	// mapping schemes
	localparam logic [2:0] MODE_1K = 3'd0;
	localparam logic [2:0] MODE_2K = 3'd1;
	localparam logic [2:0] MODE_4K = 3'd2;
	localparam logic [2:0] MODE_F8 = 3'd3;
	localparam logic [2:0] MODE_F6 = 3'd4;
	localparam logic [2:0] MODE_F4 = 3'd5;
	localparam logic [2:0] MODE_FA = 3'd6;

	// configuration register indexes
	localparam logic [2:0] CFG_MAP_MODE   = 3'd0;
	localparam logic [2:0] CFG_SUPERCHIP  = 3'd1;
	localparam logic [2:0] CFG_BANK_COUNT = 3'd2;
	localparam logic [2:0] CFG_START_BANK = 3'd3;
	localparam logic [2:0] CFG_ROM_BYTES  = 3'd4;

	// hotspot ranges
	localparam logic [12:0] HS_F8_BASE = 13'h1ff8;
	localparam logic [12:0] HS_F6_BASE = 13'h1ff6;
	localparam logic [12:0] HS_F4_BASE = 13'h1ff4;
	localparam logic [12:0] HS_F4_TOP  = 13'h1ffb;
	localparam logic [12:0] HS_FA_TOP  = 13'h1ffa;
	localparam logic [12:0] HS_F8_TOP  = 13'h1ff9;

	// RAM windows
	localparam logic [12:0] FA_RD_LO  = 13'h1100;
	localparam logic [12:0] FA_RD_HI  = 13'h11ff;
	localparam logic [12:0] FA_WR_HI  = 13'h10ff;
	localparam logic [12:0] SC_RD_LO  = 13'h1080;
	localparam logic [12:0] SC_WR_HI  = 13'h107f;

	// largest bank number a hotspot may select, plus one
	localparam logic [3:0] MAX_BANKS = 4'd8;

	// configuration seen by the decoder
	typedef struct packed {
		logic [2:0]  map_mode;
		logic        superchip;
		logic [3:0]  bank_limit;
		logic [15:0] rom_bytes;
	} cfg_t;

	// decode result for one bus access
	typedef struct packed {
		logic        sel;        // cartridge space
		logic        valid;      // read_data is the answer
		logic [7:0]  rdata;      // constant answer (zero window or 0xff)
		logic        ram_rd;     // answer comes from cart RAM
		logic        ram_we;     // write byte to cart RAM
		logic [7:0]  ram_idx;    // RAM entry, already folded to the RAM depth
		logic        fetch;      // external ROM serves the read
		logic [14:0] offset;     // physical ROM offset
		logic [2:0]  bank_next;  // bank after this access
	} dec_t;

endpackage

@@ hw/rtl/cbsm_decode.sv @@
// ----------------------------------------------------------------------------
// Cartridge mapper access decoder
// Hotspot bank switching, RAM window decode and ROM offset for one access.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbsm_decode #(
	parameter int CART_RAM_BYTES = 256
) (
	input  cbsm_pkg::cfg_t  cfg,
	input  logic [2:0]      bank,
	input  logic            is_write,
	input  logic [12:0]     bus,
	output cbsm_pkg::dec_t  dec
);

	localparam logic [7:0] FA_IDX_MASK = 8'(CART_RAM_BYTES - 1);

	logic        hs_en;
	logic [12:0] hs_base;
	logic [12:0] hs_top;
	logic [12:0] hs_diff;
	logic        hs_ok;
	logic [2:0]  bank_sw;
	logic        is_fa;
	logic        fa_wr_win;
	logic        fa_rd_win;
	logic        sc_wr_win;
	logic        sc_rd_win;
	logic [14:0] phys;

	// hotspot range for the current mode
	always_comb begin
		hs_en   = 1'b1;
		hs_base = cbsm_pkg::HS_F8_BASE;
		hs_top  = cbsm_pkg::HS_F8_TOP;
		case (cfg.map_mode)
			cbsm_pkg::MODE_F8: begin
				hs_base = cbsm_pkg::HS_F8_BASE;
				hs_top  = cbsm_pkg::HS_F8_TOP;
			end
			cbsm_pkg::MODE_F6: begin
				hs_base = cbsm_pkg::HS_F6_BASE;
				hs_top  = cbsm_pkg::HS_F8_TOP;
			end
			cbsm_pkg::MODE_F4: begin
				hs_base = cbsm_pkg::HS_F4_BASE;
				hs_top  = cbsm_pkg::HS_F4_TOP;
			end
			cbsm_pkg::MODE_FA: begin
				hs_base = cbsm_pkg::HS_F8_BASE;
				hs_top  = cbsm_pkg::HS_FA_TOP;
			end
			default: hs_en = 1'b0;
		endcase
	end

	// switch only to a bank that exists
	assign hs_diff = bus - hs_base;
	assign hs_ok   = hs_en && (bus >= hs_base) && (bus <= hs_top)
		&& (hs_diff[3:0] < cfg.bank_limit) && (hs_diff[3:0] < cbsm_pkg::MAX_BANKS);
	assign bank_sw = hs_ok ? hs_diff[2:0] : bank;

	// RAM windows (bus is known to sit at or above 0x1000 when they matter)
	assign is_fa     = (cfg.map_mode == cbsm_pkg::MODE_FA);
	assign fa_wr_win = is_fa && (bus <= cbsm_pkg::FA_WR_HI);
	assign fa_rd_win = is_fa && (bus >= cbsm_pkg::FA_RD_LO) && (bus <= cbsm_pkg::FA_RD_HI);
	assign sc_wr_win = cfg.superchip && (bus <= cbsm_pkg::SC_WR_HI);
	assign sc_rd_win = cfg.superchip && (bus >= cbsm_pkg::SC_RD_LO)
		&& (bus <= cbsm_pkg::FA_WR_HI);

	// physical ROM offset from the switched bank
	always_comb begin
		case (cfg.map_mode)
			cbsm_pkg::MODE_1K: phys = {2'b00, bank_sw, bus[9:0]};
			cbsm_pkg::MODE_2K: phys = {1'b0, bank_sw, bus[10:0]};
			default:           phys = {bank_sw, bus[11:0]};
		endcase
	end

	// access decode
	always_comb begin
		dec           = '0;
		dec.bank_next = bank;
		if (bus[12]) begin
			dec.sel = 1'b1;
			if (is_write) begin
				if (fa_wr_win) begin
					dec.ram_we  = 1'b1;
					dec.ram_idx = bus[7:0] & FA_IDX_MASK;
				end else if (sc_wr_win) begin
					dec.ram_we  = 1'b1;
					dec.ram_idx = {1'b0, bus[6:0]};
				end else begin
					dec.bank_next = bank_sw;
				end
			end else if (fa_rd_win) begin
				dec.valid   = 1'b1;
				dec.ram_rd  = 1'b1;
				dec.ram_idx = bus[7:0] & FA_IDX_MASK;
			end else if (fa_wr_win || sc_wr_win) begin
				dec.valid = 1'b1;
			end else if (sc_rd_win) begin
				dec.valid   = 1'b1;
				dec.ram_rd  = 1'b1;
				dec.ram_idx = {1'b0, bus[6:0]};
			end else begin
				dec.bank_next = bank_sw;
				if ({1'b0, phys} < cfg.rom_bytes) begin
					dec.fetch  = 1'b1;
					dec.offset = phys;
				end else begin
					dec.valid = 1'b1;
					dec.rdata = 8'hff;
				end
			end
		end
	end

endmodule

@@ hw/rtl/cbsm_ram.sv @@
// ----------------------------------------------------------------------------
// Cartridge mapper RAM
// Cart RAM with one write and one registered read port; per-entry valid bits
// make unwritten entries read as zero straight out of reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbsm_ram #(
	parameter int CART_RAM_BYTES = 256,
	parameter int AW = $clog2(CART_RAM_BYTES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic          rd_en,
	input  logic [AW-1:0] idx,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0]                mem [CART_RAM_BYTES];
	logic [CART_RAM_BYTES-1:0] vld_q;
	logic [7:0]                rd_q;
	logic                      rd_vld_q;

	// storage array and read data register
	always_ff @(posedge clk) begin
		if (we) begin
			mem[idx] <= wdata;
		end
		if (rd_en) begin
			rd_q <= mem[idx];
		end
	end

	// written-entry flags, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[idx];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_q : 8'h00;

endmodule

@@ hw/rtl/cartridge_bank_switch_mapper.sv @@
// ----------------------------------------------------------------------------
// Cartridge bank switch mapper
// Decodes CPU bus accesses for 1K/2K/4K/F8/F6/F4/FA cartridges with
// superchip and FA RAM.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  s_      | in  | s_tvalid/s_tready   | tdata: cpu_address, write_data
//          |     |                     | tuser: req_type
//  m_      | out | m_tvalid/m_tready   | tdata: read_data, rom_offset, bank_now
//          |     |                     | tuser: cart_selected, data_valid, rom_fetch
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One word per cycle sustained while the result side is not stalled; a word passes the input
// register, then the result register with the cart RAM read register beside it.
// The bank register updates as a word leaves the input register, so the
// next word already decodes with the new bank.
// Reset clears the bank and RAM valid flags and loads the config defaults at once; no clearing pass.
// A stalled result holds the input register; a new word is still taken
// while the result register is full and being drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cartridge_bank_switch_mapper_defines.svh"

module cartridge_bank_switch_mapper #(
	parameter int CART_RAM_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [15:0] cpu_address, [23:16] write_data
	input  logic        s_tuser,   // [0] req_type
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] read_data, [22:8] rom_offset, [25:23] bank_now
	output logic [2:0]  m_tuser,   // [0] cart_selected, [1] data_valid, [2] rom_fetch
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int RAM_AW = $clog2(CART_RAM_BYTES);

	cbsm_pkg::cfg_t cfg_q;
	logic [2:0]     bank_q;

	logic           v_s1;
	logic           wr_s1;
	logic [12:0]    bus_s1;
	logic [7:0]     wdata_s1;

	logic           v_s2;
	cbsm_pkg::dec_t dec_s2;

	cbsm_pkg::dec_t dec;
	logic           adv;
	logic           cfg_wr;
	logic [7:0]     ram_rdata;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// stage flow: input register advances when the result register frees up
	assign adv      = v_s1 && (!v_s2 || m_tready);
	assign s_tready = !v_s1 || adv;

	// configuration registers and current bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_mode   <= cbsm_pkg::MODE_4K;
			cfg_q.superchip  <= 1'b0;
			cfg_q.bank_limit <= 4'd1;
			cfg_q.rom_bytes  <= 16'd4096;
			bank_q           <= 3'd0;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					cbsm_pkg::CFG_MAP_MODE:   cfg_q.map_mode   <= cfg_data[2:0];
					cbsm_pkg::CFG_SUPERCHIP:  cfg_q.superchip  <= cfg_data[0];
					cbsm_pkg::CFG_BANK_COUNT: cfg_q.bank_limit <= cfg_data[3:0];
					cbsm_pkg::CFG_ROM_BYTES:  cfg_q.rom_bytes  <= cfg_data;
					default: ;
				endcase
			end
			if (cfg_wr && (cfg_index == cbsm_pkg::CFG_START_BANK)) begin
				bank_q <= cfg_data[2:0];
			end else if (adv) begin
				bank_q <= dec.bank_next;
			end
		end
	end

	// input and result register valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (adv) begin
				v_s2 <= 1'b1;
			end else if (m_tready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	// input and result payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			wr_s1    <= s_tuser;
			bus_s1   <= s_tdata[12:0];
			wdata_s1 <= s_tdata[23:16];
		end
		if (adv) begin
			dec_s2 <= dec;
		end
	end

	cbsm_decode #(
		.CART_RAM_BYTES(CART_RAM_BYTES)
	) u_decode (
		.cfg      (cfg_q),
		.bank     (bank_q),
		.is_write (wr_s1),
		.bus      (bus_s1),
		.dec      (dec)
	);

	cbsm_ram #(
		.CART_RAM_BYTES(CART_RAM_BYTES)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (adv && dec.ram_we),
		.rd_en  (adv),
		.idx    (RAM_AW'(dec.ram_idx)),
		.wdata  (wdata_s1),
		.rdata  (ram_rdata)
	);

	// result word
	assign m_tvalid = v_s2;
	assign m_tdata  = {6'd0, dec_s2.bank_next, dec_s2.offset,
		(dec_s2.ram_rd ? ram_rdata : dec_s2.rdata)};
	assign m_tuser  = {dec_s2.fetch, dec_s2.valid, dec_s2.sel};

	// a result is either answered here or fetched from ROM, never both
	`CBSM_ASSERT_NOW(a_answer_excl, m_tvalid, !(m_tuser[1] && m_tuser[2]), "valid and fetch both set")

	// a ROM fetch only comes from cartridge space
	`CBSM_ASSERT_NOW(a_fetch_in_cart, m_tvalid && m_tuser[2], m_tuser[0], "fetch outside cart")

	// with the result register empty the input side always takes a word
	`CBSM_ASSERT_NOW(a_skid_ready, !v_s2, s_tready, "input stalled with empty result register")

	// an access outside cartridge space leaves the bank alone
	`CBSM_ASSERT_NEXT(a_bank_hold, adv && !dec.sel && !cfg_valid, bank_q == $past(bank_q), "bank moved")

endmodule

@@ tb/cartridge_bank_switch_mapper_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge bank switch mapper testbench
// Streams CPU bus accesses through the mapper under a series of mapping
// setups and compares every result word field by field against a shadow
// decoder that tracks the bank register and cart RAM. Both stream sides
// stall at random.
// ----------------------------------------------------------------------------

module cartridge_bank_switch_mapper_tb;

	localparam int         RAM_DEPTH    = 256;
	localparam logic [2:0] MODE_UNUSED  = 3'd7;
	localparam logic       REQ_READ     = 1'b0;
	localparam logic       REQ_WRITE    = 1'b1;
	localparam logic [12:0] HOTSPOT_PAGE = 13'h1ff0;
	localparam logic [12:0] RAM_AREA     = 13'h1000;

	// one bus access and the result word it should produce
	typedef struct packed {
		logic        is_write;
		logic [15:0] addr;
		logic [7:0]  wdata;
	} bus_access_t;

	typedef struct packed {
		logic        sel;
		logic        valid;
		logic [7:0]  rdata;
		logic        fetch;
		logic [14:0] offset;
		logic [2:0]  bank;
	} bus_result_t;

	typedef struct packed {
		logic [2:0]  idx;
		logic [15:0] val;
	} reg_write_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // [15:0] cpu_address, [23:16] write_data
	logic        s_tuser = 1'b0; // [0] req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // [7:0] read_data, [22:8] rom_offset, [25:23] bank_now
	logic [2:0]  m_tuser;        // [0] cart_selected, [1] data_valid, [2] rom_fetch
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = cbsm_pkg::CFG_MAP_MODE;
	logic [15:0] cfg_data = '0;

	bus_access_t pending_accesses[$];
	reg_write_t  pending_reg_writes[$];
	bus_result_t expected_results[$];
	int          idle_pct = 34;
	int          fail_cnt = 0;

	// shadow mapper state
	logic [2:0]  cur_mode;
	logic        sc_on;
	logic [3:0]  banks_present;
	logic [15:0] rom_limit;
	logic [2:0]  bank_reg;
	logic [7:0]  ram_shadow[RAM_DEPTH];

	cartridge_bank_switch_mapper i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// shadow decoder
	// ------------------------------------------------------------------

	// hotspot bank switch; bank numbers not below the count or not below eight are ignored
	function automatic void switch_bank(logic [12:0] a);
		logic [12:0] lo, hi, nb;
		logic        armed;
		armed = 1'b1;
		lo = '0;
		hi = '0;
		case (cur_mode)
			cbsm_pkg::MODE_F8: begin lo = cbsm_pkg::HS_F8_BASE; hi = cbsm_pkg::HS_F8_TOP; end
			cbsm_pkg::MODE_F6: begin lo = cbsm_pkg::HS_F6_BASE; hi = cbsm_pkg::HS_F8_TOP; end
			cbsm_pkg::MODE_F4: begin lo = cbsm_pkg::HS_F4_BASE; hi = cbsm_pkg::HS_F4_TOP; end
			cbsm_pkg::MODE_FA: begin lo = cbsm_pkg::HS_F8_BASE; hi = cbsm_pkg::HS_FA_TOP; end
			default: armed = 1'b0;
		endcase
		if (armed && a >= lo && a <= hi) begin
			nb = a - lo;
			if (nb < banks_present && nb < cbsm_pkg::MAX_BANKS)
				bank_reg = nb[2:0];
		end
	endfunction

	function automatic bus_result_t decode_access(bus_access_t w);
		bus_result_t r;
		logic [12:0] a;
		logic [7:0]  fa_idx;
		logic        done;
		int unsigned sz, off, phys;
		r = '0;
		a = w.addr[12:0];
		fa_idx = a[7:0] & 8'(RAM_DEPTH - 1);
		if (a[12]) begin
			r.sel = 1'b1;
			if (w.is_write) begin
				if (cur_mode == cbsm_pkg::MODE_FA && a <= cbsm_pkg::FA_WR_HI)
					ram_shadow[fa_idx] = w.wdata;
				else if (sc_on && a <= cbsm_pkg::SC_WR_HI)
					ram_shadow[{1'b0, a[6:0]}] = w.wdata;
				else
					switch_bank(a);
			end else begin
				done = 1'b0;
				// FA windows take priority over superchip ones
				if (cur_mode == cbsm_pkg::MODE_FA) begin
					if (a >= cbsm_pkg::FA_RD_LO && a <= cbsm_pkg::FA_RD_HI) begin
						r.valid = 1'b1;
						r.rdata = ram_shadow[fa_idx];
						done = 1'b1;
					end else if (a <= cbsm_pkg::FA_WR_HI) begin
						r.valid = 1'b1;
						done = 1'b1;
					end
				end
				if (!done && sc_on) begin
					if (a >= cbsm_pkg::SC_RD_LO && a <= cbsm_pkg::FA_WR_HI) begin
						r.valid = 1'b1;
						r.rdata = ram_shadow[{1'b0, a[6:0]}];
						done = 1'b1;
					end else if (a <= cbsm_pkg::SC_WR_HI) begin
						r.valid = 1'b1;
						done = 1'b1;
					end
				end
				if (!done) begin
					switch_bank(a);
					case (cur_mode)
						cbsm_pkg::MODE_1K: begin off = a[9:0];  sz = 1024; end
						cbsm_pkg::MODE_2K: begin off = a[10:0]; sz = 2048; end
						default: begin off = a[11:0]; sz = 4096; end
					endcase
					phys = int'(bank_reg) * sz + off;
					if (phys < rom_limit) begin
						r.fetch = 1'b1;
						r.offset = phys[14:0];
					end else begin
						r.valid = 1'b1;
						r.rdata = 8'hff;
					end
				end
			end
		end
		r.bank = bank_reg;
		return r;
	endfunction

	function automatic void apply_reg(logic [2:0] idx, logic [15:0] val);
		case (idx)
			cbsm_pkg::CFG_MAP_MODE:   cur_mode = val[2:0];
			cbsm_pkg::CFG_SUPERCHIP:  sc_on = val[0];
			cbsm_pkg::CFG_BANK_COUNT: banks_present = val[3:0];
			cbsm_pkg::CFG_START_BANK: bank_reg = val[2:0];
			cbsm_pkg::CFG_ROM_BYTES:  rom_limit = val;
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------

	// access word driver; predicts each word as it is taken
	always @(posedge clk or negedge arst_n) begin : access_driver
		bus_access_t cur, nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= REQ_READ;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(decode_access(cur));
			if (!s_tvalid || s_tready) begin
				if (pending_accesses.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
					nxt = pending_accesses.pop_front();
					cur = nxt;
					s_tvalid <= 1'b1;
					s_tdata <= {nxt.wdata, nxt.addr};
					s_tuser <= nxt.is_write;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// register write driver
	always @(posedge clk or negedge arst_n) begin : reg_driver
		reg_write_t nxt;
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cfg_index <= cbsm_pkg::CFG_MAP_MODE;
			cfg_data <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
			if (!cfg_valid || cfg_ready) begin
				if (pending_reg_writes.size() > 0) begin
					nxt = pending_reg_writes.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= nxt.idx;
					cfg_data <= nxt.val;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// result monitor
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : result_monitor
		bus_result_t want, got;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.sel    = m_tuser[0];
				got.valid  = m_tuser[1];
				got.fetch  = m_tuser[2];
				got.rdata  = m_tdata[7:0];
				got.offset = m_tdata[22:8];
				got.bank   = m_tdata[25:23];
				if (expected_results.size() == 0) begin
					$error("result word with nothing expected");
					fail_cnt++;
				end else begin
					want = expected_results.pop_front();
					if (got.sel !== want.sel) begin
						$error("cart_selected: expected %0h, got %0h", want.sel, got.sel);
						fail_cnt++;
					end
					if (got.valid !== want.valid) begin
						$error("data_valid: expected %0h, got %0h", want.valid, got.valid);
						fail_cnt++;
					end
					if (got.rdata !== want.rdata) begin
						$error("read_data: expected %0h, got %0h", want.rdata, got.rdata);
						fail_cnt++;
					end
					if (got.fetch !== want.fetch) begin
						$error("rom_fetch: expected %0h, got %0h", want.fetch, got.fetch);
						fail_cnt++;
					end
					if (got.offset !== want.offset) begin
						$error("rom_offset: expected %0h, got %0h", want.offset, got.offset);
						fail_cnt++;
					end
					if (got.bank !== want.bank) begin
						$error("bank_now: expected %0h, got %0h", want.bank, got.bank);
						fail_cnt++;
					end
				end
			end
			m_tready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	task automatic queue_access(logic wr, logic [15:0] a, logic [7:0] d);
		bus_access_t w;
		w.is_write = wr;
		w.addr = a;
		w.wdata = d;
		pending_accesses.push_back(w);
	endtask

	// wait until every word and register write is taken and every result is back
	task automatic settle();
		while (pending_accesses.size() > 0 || s_tvalid || pending_reg_writes.size() > 0 ||
				cfg_valid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	task automatic configure(logic [2:0] mode, logic sc, logic [3:0] bc, logic [2:0] sb,
			logic [15:0] rom);
		pending_reg_writes.push_back('{cbsm_pkg::CFG_MAP_MODE, 16'(mode)});
		pending_reg_writes.push_back('{cbsm_pkg::CFG_SUPERCHIP, 16'(sc)});
		pending_reg_writes.push_back('{cbsm_pkg::CFG_BANK_COUNT, 16'(bc)});
		pending_reg_writes.push_back('{cbsm_pkg::CFG_START_BANK, 16'(sb)});
		pending_reg_writes.push_back('{cbsm_pkg::CFG_ROM_BYTES, rom});
		settle();
	endtask

	// addresses biased toward hotspots and RAM windows; upper bits stay random
	function automatic logic [15:0] pick_address();
		logic [15:0] a;
		int unsigned r;
		a = 16'($urandom);
		r = $urandom_range(0, 99);
		if (r < 10)
			a[12] = 1'b0;
		else if (r < 35)
			a[12:0] = HOTSPOT_PAGE | 13'($urandom_range(0, 15));
		else if (r < 65)
			a[12:0] = RAM_AREA | 13'($urandom_range(0, 511));
		else
			a[12] = 1'b1;
		return a;
	endfunction

	// random words; some RAM writes are followed by a read of the same entry
	task automatic random_burst(int n);
		bus_access_t w;
		for (int k = 0; k < n; k++) begin
			w.is_write = ($urandom_range(0, 99) < 40);
			w.addr = pick_address();
			w.wdata = 8'($urandom);
			pending_accesses.push_back(w);
			if (w.is_write && w.addr[12:8] == 5'h10 && $urandom_range(0, 2) == 0) begin
				w.is_write = REQ_READ;
				if (cur_mode == cbsm_pkg::MODE_FA)
					w.addr[12:0] = cbsm_pkg::FA_RD_LO | 13'(w.addr[7:0]);
				else
					w.addr[12:0] = cbsm_pkg::SC_RD_LO | 13'(w.addr[6:0]);
				pending_accesses.push_back(w);
				k++;
			end
		end
	endtask

	// one setup, run in two chunks with a full drain between them
	task automatic run_setting(logic [2:0] mode, logic sc, logic [3:0] bc, logic [2:0] sb,
			logic [15:0] rom, int n);
		configure(mode, sc, bc, sb, rom);
		random_burst(n / 2);
		settle();
		random_burst(n - n / 2);
		settle();
	endtask

	initial begin : stimulus
		cur_mode = cbsm_pkg::MODE_4K;
		sc_on = 1'b0;
		banks_present = 4'd1;
		rom_limit = 16'd4096;
		bank_reg = '0;
		foreach (ram_shadow[i])
			ram_shadow[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setup: plain 4K
		queue_access(REQ_READ, 16'h0000, 8'h00);
		queue_access(REQ_READ, 16'hffff, 8'h00);
		queue_access(REQ_WRITE, 16'hefff, 8'hff);
		settle();

		// F8 with superchip RAM
		configure(cbsm_pkg::MODE_F8, 1'b1, 4'd2, 3'd1, 16'd8192);
		queue_access(REQ_WRITE, 16'h1000, 8'ha5);
		queue_access(REQ_WRITE, 16'h107f, 8'h5a);
		queue_access(REQ_READ, 16'h1080, 8'h00);
		queue_access(REQ_READ, 16'h10ff, 8'h00);
		queue_access(REQ_READ, 16'h1000, 8'hff);
		queue_access(REQ_READ, 16'h1ff8, 8'h00);
		queue_access(REQ_READ, 16'hfff9, 8'h00);
		queue_access(REQ_WRITE, 16'h1ff8, 8'h00);
		queue_access(REQ_WRITE, 16'h1ffa, 8'h00);
		queue_access(REQ_READ, 16'h1400, 8'h00);
		settle();

		// FA and superchip together, FA windows first
		configure(cbsm_pkg::MODE_FA, 1'b1, 4'd15, 3'd0, 16'hffff);
		queue_access(REQ_WRITE, 16'h10ff, 8'h3c);
		queue_access(REQ_WRITE, 16'h1000, 8'h81);
		queue_access(REQ_READ, 16'h11ff, 8'h00);
		queue_access(REQ_READ, 16'h1100, 8'h00);
		queue_access(REQ_READ, 16'h1080, 8'h00);
		queue_access(REQ_READ, 16'h1ffa, 8'h00);
		queue_access(REQ_READ, 16'h1ffb, 8'h00);
		queue_access(REQ_WRITE, 16'h1ff9, 8'hff);
		settle();

		// random part over a range of setups
		run_setting(cbsm_pkg::MODE_F8, 1'b1, 4'd2, 3'd1, 16'd8192, 140);
		run_setting(cbsm_pkg::MODE_F6, 1'b0, 4'd4, 3'd0, 16'd16384, 140);
		run_setting(cbsm_pkg::MODE_F4, 1'b1, 4'd8, 3'd7, 16'd32768, 140);
		// long stretch with no stalls on either side
		idle_pct = 0;
		run_setting(cbsm_pkg::MODE_FA, 1'b0, 4'd3, 3'd2, 16'd12288, 140);
		idle_pct = 34;
		run_setting(cbsm_pkg::MODE_FA, 1'b1, 4'd15, 3'd0, 16'hffff, 140);
		// start bank past the bank count, ROM too short for it
		run_setting(cbsm_pkg::MODE_1K, 1'b0, 4'd1, 3'd3, 16'd1024, 140);
		// no banks: every switch ignored; empty ROM
		run_setting(cbsm_pkg::MODE_2K, 1'b1, 4'd0, 3'd5, 16'd0, 140);
		run_setting(MODE_UNUSED, 1'b0, 4'd8, 3'd4, 16'd32768, 140);
		run_setting(cbsm_pkg::MODE_F4, 1'b0, 4'd6, 3'd5, 16'd20000, 140);

		settle();
		repeat (8) @(posedge clk);
		if (fail_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
